// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- hw/rtl/swjag_pkg.sv -----
// Types, constants and tables for the sidewinding joint angle generator.
`timescale 1ns / 1ps
package swjag_pkg;
    localparam int MAX_JOINTS_DEF = 16;
    localparam int CORDIC_STEPS   = 16;
    localparam logic [29:0] TURN_PER_RAD = 30'd683565276;
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
    localparam logic [31:0] OFS_ODD  = 32'h4000_0000;
    localparam logic [31:0] OFS_EVEN = 32'h2000_0000;

    typedef enum logic [1:0] {
        CFG_RADIUS = 2'd0,
        CFG_RISE   = 2'd1,
        CFG_LINK   = 2'd2,
        CFG_JOINTS = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_RR, ST_MUL_BB, ST_SUM, ST_DIV_G, ST_WAIT_G,
        ST_MUL_K, ST_DIV_T, ST_WAIT_T, ST_J_ACC, ST_J_ROT, ST_J_WAIT,
        ST_J_MUL, ST_J_EMIT
    } t_state;

    typedef enum logic [2:0] {
        MUL_NONE, MUL_RR, MUL_BB, MUL_DR, MUL_BD, MUL_BDK, MUL_GY
    } t_mul_sel;

    typedef struct packed {
        t_mul_sel mul_sel;
        logic     div_start;
        logic     div_gain;
        logic     cor_start;
        logic     emit;
    } t_ctl;

    function automatic logic [29:0] atan_turn(input logic [3:0] idx);
        logic [29:0] v;
        case (idx)
            4'd0:  v = 30'd536870912;
            4'd1:  v = 30'd316933406;
            4'd2:  v = 30'd167458907;
            4'd3:  v = 30'd85004756;
            4'd4:  v = 30'd42667331;
            4'd5:  v = 30'd21354465;
            4'd6:  v = 30'd10679838;
            4'd7:  v = 30'd5340245;
            4'd8:  v = 30'd2670163;
            4'd9:  v = 30'd1335087;
            4'd10: v = 30'd667544;
            4'd11: v = 30'd333772;
            4'd12: v = 30'd166886;
            4'd13: v = 30'd83443;
            4'd14: v = 30'd41722;
            4'd15: v = 30'd20861;
            default: v = 30'd0;
        endcase
        return v;
    endfunction
endpackage

// ----- hw/rtl/swjag_div.sv -----
// Bit-serial restoring divider: 64-bit dividend, 33-bit divisor, low 32 quotient bits.
`timescale 1ns / 1ps
module swjag_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [32:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot
);
    logic [33:0] r_rem;
    logic [63:0] r_num;
    logic [32:0] r_den;
    logic [31:0] r_quot;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [33:0] w_sh;
    logic        w_ge;

    assign w_sh = {r_rem[32:0], r_num[63]};
    assign w_ge = (w_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_num <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem  <= w_ge ? (w_sh - {1'b0, r_den}) : w_sh;
            r_num  <= {r_num[62:0], 1'b0};
            r_quot <= {r_quot[30:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// ----- hw/rtl/swjag_cordic.sv -----
// Iterative rotation-mode CORDIC giving sin of a phase in 2^-32 turn, Q30.
`timescale 1ns / 1ps
module swjag_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_theta,
    output logic               o_done,
    output logic signed [33:0] o_sin
);
    import swjag_pkg::*;
    logic signed [33:0] r_x, r_y, r_z;
    logic [3:0]         r_cnt;
    logic               r_busy, r_done;
    logic signed [33:0] w_s, w_fold, w_dx, w_dy, w_at;

    always_comb begin
        w_s = 34'(signed'(i_theta));
        if (w_s > 34'sd1073741824)
            w_fold = 34'sd2147483648 - w_s;
        else if (w_s < -34'sd1073741824)
            w_fold = -34'sd2147483648 - w_s;
        else
            w_fold = w_s;
        w_dx = r_y >>> r_cnt;
        w_dy = r_x >>> r_cnt;
        w_at = signed'({4'b0, atan_turn(r_cnt)});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= CORDIC_X0;
            r_y <= '0;
            r_z <= w_fold;
        end else if (r_busy) begin
            if (!r_z[33]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_at;
            end
        end
    end

    assign o_done = r_done;
    assign o_sin  = r_y;
endmodule

// ----- hw/rtl/sidewinding_joint_angle_gen_top.sv -----
// Sidewinding joint angle generator: sequencer, shared multiplier, divider and CORDIC.
// Each accepted gait phase yields one angle per joint (joint_count, clipped to 1..MAX_JOINTS).
// Setup for an input runs two serial divisions, for the gain and the torsion step;
// each joint then takes a 16-step CORDIC, the shared multiplier and rounding, and
// a joint waits in its emit state while the output stalls.
// When radius and rise are both zero the divisions and CORDIC are skipped and each angle
// is 0 with the saturated flag set. The input is not ready until the last angle is loaded.
`timescale 1ns / 1ps
module sidewinding_joint_angle_gen_top #(
    parameter int MAX_JOINTS = swjag_pkg::MAX_JOINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] gait_phase
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [3:0] joint_index, [19:4] joint_angle, [23:20] zero
    output logic        o_m_tuser,   // [0] saturated
    output logic        o_m_tlast
);
    import swjag_pkg::*;
    localparam int CW = $clog2(MAX_JOINTS + 1);

    logic [15:0] r_radius, r_rise, r_link;
    logic [4:0]  r_jcount;
    t_state      r_state, n_state;
    t_ctl        w_ctl;
    logic [15:0] r_psi;
    logic [63:0] r_prod, r_tmp;
    logic [32:0] r_den;
    logic [32:0] w_den;
    logic        r_degen;
    logic [31:0] r_gain, r_step, r_acc;
    logic [CW-1:0] r_idx, r_n, w_n;
    logic        w_last, w_out_free;
    logic signed [33:0] w_ma, w_mb;
    logic signed [67:0] w_mp;
    logic        w_div_done, w_cor_done;
    logic [31:0] w_quot;
    logic signed [33:0] w_sin;
    logic [31:0] w_theta;
    logic [63:0] w_mag;
    logic [30:0] w_q;
    logic [15:0] w_angle;
    logic        w_sat;
    logic        r_ovalid, r_olast, r_osat;
    logic [3:0]  r_oidx;
    logic [15:0] r_oang;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 16'd6554;
            r_rise   <= 16'd3277;
            r_link   <= 16'd4588;
            r_jcount <= 5'd16;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_RADIUS: r_radius <= i_cfg_data;
                CFG_RISE:   r_rise   <= i_cfg_data;
                CFG_LINK:   r_link   <= i_cfg_data;
                CFG_JOINTS: r_jcount <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_jcount == 5'd0)
            w_n = CW'(1);
        else if (32'(r_jcount) > MAX_JOINTS)
            w_n = CW'(MAX_JOINTS);
        else
            w_n = CW'(r_jcount);
    end

    assign w_den      = 33'(r_tmp[31:0]) + 33'(r_prod[31:0]);
    assign w_last     = (r_idx == r_n - CW'(1));
    assign w_out_free = !r_ovalid || i_m_tready;
    assign w_theta    = r_acc + {r_psi, 16'd0} + (r_idx[0] ? OFS_ODD : OFS_EVEN);
    assign o_s_tready = (r_state == ST_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_s_tvalid) n_state = ST_MUL_RR;
            ST_MUL_RR: n_state = ST_MUL_BB;
            ST_MUL_BB: n_state = ST_SUM;
            ST_SUM:    n_state = (w_den == 33'd0) ? ST_J_ACC : ST_DIV_G;
            ST_DIV_G:  n_state = ST_WAIT_G;
            ST_WAIT_G: if (w_div_done) n_state = ST_MUL_K;
            ST_MUL_K:  n_state = ST_DIV_T;
            ST_DIV_T:  n_state = ST_WAIT_T;
            ST_WAIT_T: if (w_div_done) n_state = ST_J_ACC;
            ST_J_ACC:  n_state = r_degen ? ST_J_EMIT : ST_J_ROT;
            ST_J_ROT:  n_state = ST_J_WAIT;
            ST_J_WAIT: if (w_cor_done) n_state = ST_J_MUL;
            ST_J_MUL:  n_state = ST_J_EMIT;
            ST_J_EMIT: if (w_out_free) n_state = w_last ? ST_IDLE : ST_J_ACC;
            default:   n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        w_ctl = '{mul_sel: MUL_NONE, div_start: 1'b0, div_gain: 1'b0,
                  cor_start: 1'b0, emit: 1'b0};
        case (r_state)
            ST_MUL_RR: w_ctl.mul_sel = MUL_RR;
            ST_MUL_BB: w_ctl.mul_sel = MUL_BB;
            ST_SUM:    w_ctl.mul_sel = MUL_DR;
            ST_DIV_G: begin
                w_ctl.div_start = 1'b1;
                w_ctl.div_gain  = 1'b1;
                w_ctl.mul_sel   = MUL_BD;
            end
            ST_MUL_K:  w_ctl.mul_sel = MUL_BDK;
            ST_DIV_T:  w_ctl.div_start = 1'b1;
            ST_J_ROT:  w_ctl.cor_start = 1'b1;
            ST_J_MUL:  w_ctl.mul_sel = MUL_GY;
            ST_J_EMIT: w_ctl.emit = w_out_free;
            default: ;
        endcase
    end

    // shared multiplier operands
    always_comb begin
        case (w_ctl.mul_sel)
            MUL_RR:  begin w_ma = signed'(34'(r_radius)); w_mb = signed'(34'(r_radius)); end
            MUL_BB:  begin w_ma = signed'(34'(r_rise));   w_mb = signed'(34'(r_rise));   end
            MUL_DR:  begin w_ma = signed'(34'(r_link));   w_mb = signed'(34'(r_radius)); end
            MUL_BD:  begin w_ma = signed'(34'(r_rise));   w_mb = signed'(34'(r_link));   end
            MUL_BDK: begin
                w_ma = signed'(34'(r_prod[31:0]));
                w_mb = signed'(34'(TURN_PER_RAD));
            end
            MUL_GY:  begin w_ma = signed'(34'(r_gain)); w_mb = w_sin; end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
        w_mp = w_ma * w_mb;
    end

    // round half away from zero to Q13 and clip
    always_comb begin
        w_mag = r_prod[63] ? (64'd0 - r_prod) : r_prod;
        w_q   = 31'((w_mag + 64'h1_0000_0000) >> 33);
        w_sat = 1'b0;
        if (r_degen) begin
            w_angle = 16'd0;
            w_sat   = 1'b1;
        end else if (r_prod[63]) begin
            if (w_q > 31'd32768) begin
                w_angle = 16'h8000;
                w_sat   = 1'b1;
            end else begin
                w_angle = 16'd0 - w_q[15:0];
            end
        end else begin
            if (w_q > 31'd32767) begin
                w_angle = 16'h7FFF;
                w_sat   = 1'b1;
            end else begin
                w_angle = w_q[15:0];
            end
        end
    end

    swjag_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ctl.div_start),
        .i_num   (w_ctl.div_gain ? {16'd0, r_prod[31:0], 16'd0} : r_prod),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    swjag_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ctl.cor_start),
        .i_theta (w_theta),
        .o_done  (w_cor_done),
        .o_sin   (w_sin)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ctl.emit)
                r_ovalid <= 1'b1;
            else if (i_m_tready)
                r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_s_tvalid) begin
            r_psi <= i_s_tdata;
            r_n   <= w_n;
        end
        if (w_ctl.mul_sel != MUL_NONE)
            r_prod <= w_mp[63:0];
        if (r_state == ST_MUL_BB)
            r_tmp <= r_prod;
        if (r_state == ST_SUM) begin
            r_den   <= w_den;
            r_degen <= (w_den == 33'd0);
            r_acc   <= '0;
            r_idx   <= '0;
            if (w_den == 33'd0) begin
                r_gain <= '0;
                r_step <= '0;
            end
        end
        if (r_state == ST_WAIT_G && w_div_done)
            r_gain <= w_quot;
        if (r_state == ST_WAIT_T && w_div_done)
            r_step <= w_quot;
        if (r_state == ST_J_ACC)
            r_acc <= r_acc + r_step;
        if (w_ctl.emit) begin
            r_oidx  <= 4'(r_idx);
            r_oang  <= w_angle;
            r_osat  <= w_sat;
            r_olast <= w_last;
            r_idx   <= r_idx + CW'(1);
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {4'd0, r_oang, r_oidx};
    assign o_m_tuser  = r_osat;
    assign o_m_tlast  = r_olast;
endmodule

// ----- hw/rtl/swjag_checker.sv -----
// Port-level checker for the joint angle generator, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module swjag_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic        o_m_tlast
);
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid, "output dropped while stalled")
    `ASSERT_CLK(a_busy_after_in, i_clk, i_rst_n, i_s_tvalid && o_s_tready |=> !o_s_tready, "ready right after an input transfer")
    `ASSERT_CLK(a_busy_mid_run, i_clk, i_rst_n, o_m_tvalid && i_m_tready && !o_m_tlast |-> !o_s_tready, "ready before the last angle")
    `ASSERT_ALWAYS(a_rst_idle, i_clk, i_rst_n && !$past(i_rst_n) |-> !o_m_tvalid, "output valid after reset")
endmodule

bind sidewinding_joint_angle_gen_top swjag_checker u_swjag_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tlast  (o_m_tlast)
);
